// File: sv/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants for the subframe descriptor table.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int DATA_CAPACITY_DEF = 1024;
  localparam int MAX_ENTRIES_DEF   = 15;

  // action codes
  localparam logic [2:0] ACT_RESTART = 3'd0;
  localparam logic [2:0] ACT_APPEND  = 3'd1;
  localparam logic [2:0] ACT_FIND    = 3'd2;
  localparam logic [2:0] ACT_SETLEN  = 3'd3;
  localparam logic [2:0] ACT_REMOVE  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch a new item, rewind the table walk
    logic step;   // advance the walk by one entry
    logic exec;   // apply the action, register the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;   // walk finished (hit, miss, or action needs no walk)
  } sts_t;

endpackage

// File: sv/pst_ctrl.sv
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer: load an item, walk the table until the datapath reports done,
// then apply the action for one cycle.
// ----------------------------------------------------------------------------
module pst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output pst_pkg::cmd_t     cmd,
  input  pst_pkg::sts_t     sts
);

  pst_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != pst_pkg::S_IDLE);
    unique case (state_r)
      pst_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = pst_pkg::S_SCAN;
        end
      end
      pst_pkg::S_SCAN: begin
        if (sts.done) begin
          state_nxt = pst_pkg::S_EXEC;
        end else begin
          cmd.step = 1'b1;
        end
      end
      pst_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = pst_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pst_pkg::S_IDLE;
      end
    endcase
  end

  a_exec_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pst_pkg::S_EXEC |=> state_r == pst_pkg::S_IDLE)
    else $error("exec not followed by idle");

  a_step_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !sts.done)
    else $error("walk advanced after it finished");

endmodule

// File: sv/pst_dp.sv
// ----------------------------------------------------------------------------
// pst_dp
// Descriptor table, entry count, used bytes, table walk and result registers.
// ----------------------------------------------------------------------------
module pst_dp #(
  parameter int DATA_CAPACITY = pst_pkg::DATA_CAPACITY_DEF,
  parameter int MAX_ENTRIES   = pst_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pst_pkg::cmd_t     cmd,
  output pst_pkg::sts_t     sts,
  input  logic [2:0]        in_action,
  input  logic [7:0]        in_sub_type,
  input  logic [7:0]        in_occurrence,
  input  logic [10:0]       in_sub_length,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [11:0]       out_byte_offset,
  output logic [10:0]       out_found_length,
  output logic [3:0]        out_entry_count,
  output logic [11:0]       out_packet_size
);

  localparam int          IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [11:0] CAP   = 12'(DATA_CAPACITY);
  localparam logic [3:0]  MAXC  = 4'(MAX_ENTRIES);

  function automatic logic [11:0] pkt_offset(input logic [3:0] cnt,
                                             input logic [11:0] pos);
    pkt_offset = 12'd12 + {6'd0, cnt, 2'b00} + pos;
  endfunction

  // latched item
  logic [2:0]  action_r;
  logic [7:0]  type_r;
  logic [7:0]  left_r, left_nxt;
  logic [10:0] len_r;

  // walk and state
  logic [3:0]  scan_idx_r, scan_idx_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [11:0] used_r, used_nxt;

  // table
  logic [7:0]  typ_r [MAX_ENTRIES];
  logic [11:0] pos_r [MAX_ENTRIES];
  logic [10:0] ent_len_r [MAX_ENTRIES];
  logic [7:0]  typ_nxt [MAX_ENTRIES];
  logic [11:0] pos_nxt [MAX_ENTRIES];
  logic [10:0] ent_len_nxt [MAX_ENTRIES];

  // results
  logic        out_valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [11:0] offset_r, offset_nxt;
  logic [10:0] flen_r, flen_nxt;
  logic [3:0]  ocount_r;
  logic [11:0] psize_r;

  logic [IDX_W-1:0] idx;
  logic        is_search, cur_valid, match, hit, miss;
  logic [11:0] space, alloc, freed;
  logic [11:0] hit_pos;
  logic [10:0] hit_len;
  logic        no_space, full;
  logic        do_append, do_setlen, do_remove;

  // ---------------------------------------------------------------- walk
  assign idx       = scan_idx_r[IDX_W-1:0];
  assign is_search = (action_r == pst_pkg::ACT_FIND) || (action_r == pst_pkg::ACT_SETLEN) ||
                     (action_r == pst_pkg::ACT_REMOVE);
  assign cur_valid = (scan_idx_r < count_r);
  assign match     = cur_valid && (typ_r[idx] == type_r);
  assign hit       = is_search && match && (left_r == 8'd1);
  assign miss      = !cur_valid || (left_r == 8'd0);
  assign sts.done  = !is_search || hit || miss;

  always_comb begin
    scan_idx_nxt = scan_idx_r;
    left_nxt     = left_r;
    if (cmd.load) begin
      scan_idx_nxt = 4'd0;
      left_nxt     = in_occurrence;
    end else if (cmd.step) begin
      scan_idx_nxt = scan_idx_r + 4'd1;
      if (match) begin
        left_nxt = left_r - 8'd1;
      end
    end
  end

  // ---------------------------------------------------------------- action
  assign hit_pos  = pos_r[idx];
  assign hit_len  = ent_len_r[idx];
  assign space    = (used_r > CAP) ? 12'd0 : (CAP - used_r);
  assign alloc    = ({1'b0, len_r} + 12'd3) & 12'hFFC;
  assign freed    = ({1'b0, hit_len} + 12'd3) & 12'h7FC;
  assign no_space = ({1'b0, len_r} > space);
  assign full     = (count_r >= MAXC);

  assign do_append = cmd.exec && (action_r == pst_pkg::ACT_APPEND) && !no_space && !full;
  assign do_setlen = cmd.exec && (action_r == pst_pkg::ACT_SETLEN) && hit;
  assign do_remove = cmd.exec && (action_r == pst_pkg::ACT_REMOVE) && hit;

  always_comb begin
    status_nxt = pst_pkg::ST_OK;
    offset_nxt = 12'd0;
    flen_nxt   = 11'd0;
    count_nxt  = count_r;
    used_nxt   = used_r;
    unique case (action_r)
      pst_pkg::ACT_RESTART: begin
        count_nxt = 4'd0;
        used_nxt  = 12'd0;
      end
      pst_pkg::ACT_APPEND: begin
        if (no_space) begin
          status_nxt = pst_pkg::ST_NO_SPACE;
        end else if (full) begin
          status_nxt = pst_pkg::ST_FULL;
        end else begin
          count_nxt  = count_r + 4'd1;
          offset_nxt = pkt_offset(count_r + 4'd1, used_r);
          flen_nxt   = len_r;
          used_nxt   = used_r + alloc;
        end
      end
      pst_pkg::ACT_FIND, pst_pkg::ACT_SETLEN, pst_pkg::ACT_REMOVE: begin
        if (!hit) begin
          status_nxt = pst_pkg::ST_NOT_FOUND;
        end else if (action_r == pst_pkg::ACT_FIND) begin
          offset_nxt = pkt_offset(count_r, hit_pos);
          flen_nxt   = hit_len;
        end else if (action_r == pst_pkg::ACT_SETLEN) begin
          offset_nxt = pkt_offset(count_r, hit_pos);
          flen_nxt   = len_r;
        end else begin
          flen_nxt  = hit_len;
          count_nxt = count_r - 4'd1;
          used_nxt  = used_r - freed;
        end
      end
      default: begin
        // unused codes leave everything as is
      end
    endcase
  end

  // per-entry update: append write, length rewrite, compaction on remove
  always_comb begin
    int          nb;
    logic [11:0] src_pos;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      nb             = (j + 1 < MAX_ENTRIES) ? j + 1 : j;
      typ_nxt[j]     = typ_r[j];
      pos_nxt[j]     = pos_r[j];
      ent_len_nxt[j] = ent_len_r[j];
      src_pos        = pos_r[j];
      if (do_append && (4'(j) == count_r)) begin
        typ_nxt[j]     = type_r;
        pos_nxt[j]     = used_r;
        ent_len_nxt[j] = len_r;
      end
      if (do_setlen && (4'(j) == scan_idx_r)) begin
        ent_len_nxt[j] = len_r;
      end
      if (do_remove) begin
        if ((4'(j) >= scan_idx_r) && (4'(j + 1) < count_r)) begin
          typ_nxt[j]     = typ_r[nb];
          ent_len_nxt[j] = ent_len_r[nb];
          src_pos        = pos_r[nb];
        end
        pos_nxt[j] = (src_pos > hit_pos) ? (src_pos - freed) : src_pos;
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r  <= 4'd0;
      count_r     <= 4'd0;
      used_r      <= 12'd0;
      out_valid_r <= 1'b0;
    end else begin
      scan_idx_r  <= scan_idx_nxt;
      out_valid_r <= cmd.exec;
      if (cmd.exec) begin
        count_r <= count_nxt;
        used_r  <= used_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    if (cmd.load) begin
      action_r <= in_action;
      type_r   <= in_sub_type;
      len_r    <= in_sub_length;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      offset_r <= offset_nxt;
      flen_r   <= flen_nxt;
      ocount_r <= count_nxt;
      psize_r  <= pkt_offset(count_nxt, used_nxt);
    end
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      typ_r[j]     <= typ_nxt[j];
      pos_r[j]     <= pos_nxt[j];
      ent_len_r[j] <= ent_len_nxt[j];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_byte_offset  = offset_r;
  assign out_found_length = flen_r;
  assign out_entry_count  = ocount_r;
  assign out_packet_size  = psize_r;

  a_exec_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r && out_entry_count == count_r)
    else $error("result not presented after exec");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_idx_r <= count_r)
    else $error("table walk ran past the entry count");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_remove |=> count_r == $past(count_r) - 4'd1)
    else $error("remove did not drop the entry count");

endmodule

// File: sv/packet_subframe_table.sv
// ----------------------------------------------------------------------------
// packet_subframe_table
// Subframe descriptor table: restart, append, find, set length and remove.
// ----------------------------------------------------------------------------
// Sequence: a transfer on start loads the item, S_SCAN walks k table entries
//   (0 for restart, append and unused codes; up to entry_count for find, set
//   length and remove: 0..15), then S_EXEC applies the action and registers
//   out_valid. Busy stays high from S_SCAN to S_EXEC, so a new item is taken
//   only after the last one is applied; the walk visits one entry per cycle.
// Reset: synchronous rst_n clears entry count and used bytes; table contents
//   are not cleared. Results are never stalled by the receiver.
// ----------------------------------------------------------------------------
module packet_subframe_table #(
  parameter int DATA_CAPACITY = pst_pkg::DATA_CAPACITY_DEF,
  parameter int MAX_ENTRIES   = pst_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_sub_type,
  input  logic [7:0]  in_occurrence,
  input  logic [10:0] in_sub_length,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [11:0] out_byte_offset,
  output logic [10:0] out_found_length,
  output logic [3:0]  out_entry_count,
  output logic [11:0] out_packet_size
);

  pst_pkg::cmd_t cmd;
  pst_pkg::sts_t sts;

  pst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  pst_dp #(
    .DATA_CAPACITY (DATA_CAPACITY),
    .MAX_ENTRIES   (MAX_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_sub_type      (in_sub_type),
    .in_occurrence    (in_occurrence),
    .in_sub_length    (in_sub_length),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_byte_offset  (out_byte_offset),
    .out_found_length (out_found_length),
    .out_entry_count  (out_entry_count),
    .out_packet_size  (out_packet_size)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the subframe descriptor table. Directed sequences
// fill the table, hit the space and full limits, look up, resize and remove
// entries (including removals that free nothing or wrap the data positions),
// then random traffic biased toward valid lookups. A local copy of the table
// predicts every result, which is compared field by field as it arrives.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CAPACITY   = pst_pkg::DATA_CAPACITY_DEF;
  localparam int ENTRIES    = pst_pkg::MAX_ENTRIES_DEF;
  localparam int N_RANDOM   = 1500;
  localparam int MAX_SHOWN  = 10;
  localparam int TIMEOUT_NS = 4_000_000;

  // codes the block ignores
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] byte_offset;
    logic [10:0] found_length;
    logic [3:0]  entry_count;
    logic [11:0] packet_size;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_action;
  logic [7:0]  in_sub_type;
  logic [7:0]  in_occurrence;
  logic [10:0] in_sub_length;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [11:0] out_byte_offset;
  logic [10:0] out_found_length;
  logic [3:0]  out_entry_count;
  logic [11:0] out_packet_size;

  // mirror of the descriptor table
  logic [3:0]  tbl_count = '0;
  logic [11:0] tbl_used  = '0;
  logic [7:0]  tbl_type [ENTRIES];
  logic [11:0] tbl_pos  [ENTRIES];
  logic [10:0] tbl_len  [ENTRIES];

  result_t expected_results[$];
  int      transfers      = 0;
  int      results_seen   = 0;
  int      mismatches     = 0;
  int      peak_count     = 0;
  int      burst_left     = 1;
  int      status_seen[4] = '{0, 0, 0, 0};

  always #5 clk = ~clk;

  packet_subframe_table #(
    .DATA_CAPACITY(CAPACITY),
    .MAX_ENTRIES  (ENTRIES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_sub_type     (in_sub_type),
    .in_occurrence   (in_occurrence),
    .in_sub_length   (in_sub_length),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_byte_offset (out_byte_offset),
    .out_found_length(out_found_length),
    .out_entry_count (out_entry_count),
    .out_packet_size (out_packet_size)
  );

  // ---------------------------------------------------------------- predictor
  // 12 + 4 * count + pos, modulo 4096; also gives the packet size from used
  function automatic logic [11:0] header_plus(logic [11:0] pos);
    return 12'(12 + 4 * int'(tbl_count) + int'(pos));
  endfunction

  function automatic int find_entry(logic [7:0] typ, logic [7:0] nth);
    int left;
    left = nth;
    for (int i = 0; i < tbl_count && left > 0; i++) begin
      if (tbl_type[i] == typ) begin
        if (left == 1) return i;
        left--;
      end
    end
    return -1;
  endfunction

  function automatic result_t table_apply(logic [2:0] act, logic [7:0] typ,
                                          logic [7:0] nth, logic [10:0] len);
    result_t     r;
    int          idx;
    int          space;
    int          freed;
    logic [11:0] pos;
    r = '0;
    r.status = pst_pkg::ST_OK;
    case (act)
      pst_pkg::ACT_RESTART: begin
        tbl_count = '0;
        tbl_used  = '0;
      end
      pst_pkg::ACT_APPEND: begin
        space = (int'(tbl_used) > CAPACITY) ? 0 : CAPACITY - int'(tbl_used);
        if (int'(len) > space) begin
          r.status = pst_pkg::ST_NO_SPACE;
        end else if (int'(tbl_count) >= ENTRIES) begin
          r.status = pst_pkg::ST_FULL;
        end else begin
          tbl_type[tbl_count] = typ;
          tbl_pos[tbl_count]  = tbl_used;
          tbl_len[tbl_count]  = len;
          tbl_count = tbl_count + 1'b1;
          r.byte_offset  = header_plus(tbl_used);
          r.found_length = len;
          tbl_used = 12'(int'(tbl_used) + ((int'(len) + 3) & ~3));
        end
      end
      pst_pkg::ACT_FIND, pst_pkg::ACT_SETLEN, pst_pkg::ACT_REMOVE: begin
        idx = find_entry(typ, nth);
        if (idx < 0) begin
          r.status = pst_pkg::ST_NOT_FOUND;
        end else if (act == pst_pkg::ACT_FIND) begin
          r.byte_offset  = header_plus(tbl_pos[idx]);
          r.found_length = tbl_len[idx];
        end else if (act == pst_pkg::ACT_SETLEN) begin
          tbl_len[idx]   = len;
          r.byte_offset  = header_plus(tbl_pos[idx]);
          r.found_length = len;
        end else begin
          // lengths set past the allocation free more than was taken (2045..2047 free nothing)
          pos   = tbl_pos[idx];
          freed = (int'(tbl_len[idx]) + 3) & 'h7FC;
          r.found_length = tbl_len[idx];
          for (int i = idx; i + 1 < tbl_count; i++) begin
            tbl_type[i] = tbl_type[i + 1];
            tbl_pos[i]  = tbl_pos[i + 1];
            tbl_len[i]  = tbl_len[i + 1];
          end
          tbl_count = tbl_count - 1'b1;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_pos[i] > pos) tbl_pos[i] = 12'(int'(tbl_pos[i]) - freed);
          end
          tbl_used = 12'(int'(tbl_used) - freed);
        end
      end
      default: ;
    endcase
    r.entry_count = tbl_count;
    r.packet_size = header_plus(tbl_used);
    return r;
  endfunction

  // ------------------------------------------------------------------ sender
  task automatic send_item(input logic [2:0] act, input logic [7:0] typ,
                           input logic [7:0] nth, input logic [10:0] len);
    int gap;
    start         <= 1'b1;
    in_action     <= act;
    in_sub_type   <= typ;
    in_occurrence <= nth;
    in_sub_length <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer taken at this edge
    expected_results.push_back(table_apply(act, typ, nth, len));
    transfers++;
    if (int'(tbl_count) > peak_count) peak_count = tbl_count;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
  endtask

  // ----------------------------------------------------------------- checker
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_valid) begin
      got = {out_status, out_byte_offset, out_found_length, out_entry_count,
             out_packet_size};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: result with no transfer pending: %p", $realtime, got);
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        status_seen[got.status]++;
        if (got.status !== want.status || got.byte_offset !== want.byte_offset ||
            got.found_length !== want.found_length ||
            got.entry_count !== want.entry_count ||
            got.packet_size !== want.packet_size) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: result %0d mismatch\n  expected %p\n  actual   %p",
                     $realtime, results_seen, want, got);
        end
      end
    end
  end

  // --------------------------------------------------------------- stimulus
  function automatic logic [7:0] pick_type();
    logic [7:0] pool [4] = '{8'h00, 8'hFF, 8'h3C, 8'hA5};
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [10:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 11'($urandom_range(0, 64));
    if (r < 8) return 11'($urandom_range(0, 255));
    if (r == 8) return 11'($urandom_range(0, CAPACITY));
    return 11'($urandom_range(0, 2047));
  endfunction

  // occurrence number that selects table entry j
  function automatic logic [7:0] occurrence_of(int j);
    int n;
    n = 0;
    for (int i = 0; i <= j; i++) if (tbl_type[i] == tbl_type[j]) n++;
    return 8'(n);
  endfunction

  task automatic test_fill_table();
    logic [7:0]  typ;
    logic [10:0] len;
    send_item(pst_pkg::ACT_RESTART, 8'hFF, 8'hFF, 11'h7FF);
    for (int i = 0; i < ENTRIES; i++) begin
      typ = (i % 2 == 1) ? 8'hFF : 8'h00;
      if (i == 0) len = 11'd0;
      else if (i == 1) len = 11'd1;
      else if (i < ENTRIES - 1) len = 11'd64;
      else len = 11'(CAPACITY - int'(tbl_used));  // data area exactly full
      send_item(pst_pkg::ACT_APPEND, typ, 8'h00, len);
    end
    send_item(pst_pkg::ACT_APPEND, 8'h5A, 8'h01, 11'd0);   // fits, but table is full
    send_item(pst_pkg::ACT_APPEND, 8'h5A, 8'h01, 11'd1);   // space check wins
  endtask

  task automatic test_lookup();
    send_item(pst_pkg::ACT_FIND, 8'hFF, 8'd0, 11'd0);
    send_item(pst_pkg::ACT_FIND, 8'hFF, 8'd255, 11'd0);
    send_item(pst_pkg::ACT_FIND, 8'hFF, 8'd7, 11'd0);
    send_item(pst_pkg::ACT_FIND, 8'h00, 8'd9, 11'd0);
    send_item(pst_pkg::ACT_SETLEN, 8'hFF, 8'd1, 11'h7FF);
    send_item(pst_pkg::ACT_REMOVE, 8'hFF, 8'd1, 11'd0);    // 2047 frees nothing
    send_item(pst_pkg::ACT_SETLEN, 8'h00, 8'd1, 11'd2000);
    send_item(pst_pkg::ACT_REMOVE, 8'h00, 8'd1, 11'd0);    // frees past allocation, wraps
    send_item(pst_pkg::ACT_APPEND, 8'h11, 8'd1, 11'h7FF);
    send_item(pst_pkg::ACT_FIND, 8'h00, 8'd1, 11'd0);
  endtask

  task automatic test_unused_codes();
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      send_item(3'(a), 8'hFF, 8'hFF, 11'h7FF);
    send_item(pst_pkg::ACT_RESTART, 8'h00, 8'h00, 11'd0);
  endtask

  task automatic test_random(input int n_items);
    int          pick;
    int          j;
    logic [2:0]  act;
    logic [7:0]  typ;
    logic [7:0]  nth;
    logic [10:0] len;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      typ  = pick_type();
      nth  = 8'($urandom_range(1, 3));
      len  = pick_length();
      if (pick < 2) begin
        act = pst_pkg::ACT_RESTART;
      end else if (pick < 5) begin
        act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        nth = 8'($urandom);
      end else if (pick < 45) begin
        act = pst_pkg::ACT_APPEND;
      end else begin
        act = (pick < 65) ? pst_pkg::ACT_FIND :
              (pick < 78) ? pst_pkg::ACT_SETLEN : pst_pkg::ACT_REMOVE;
        // mostly aim at a live entry so the walk finds something
        if (tbl_count > 0 && $urandom_range(0, 7) != 0) begin
          j   = $urandom_range(0, int'(tbl_count) - 1);
          typ = tbl_type[j];
          nth = occurrence_of(j);
        end else if ($urandom_range(0, 1) == 1) begin
          nth = 8'($urandom_range(0, 255));
        end
      end
      send_item(act, typ, nth, len);
    end
  endtask

  // ------------------------------------------------------------------- main
  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_action     <= pst_pkg::ACT_RESTART;
    in_sub_type   <= '0;
    in_occurrence <= '0;
    in_sub_length <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_table();
    test_lookup();
    test_unused_codes();
    test_random(N_RANDOM);

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d transfers, %0d results checked, table fill up to %0d of %0d",
             transfers, results_seen, peak_count, ENTRIES);
    $display("Status mix: ok %0d, not found %0d, no space %0d, full %0d; mismatches %0d",
             status_seen[pst_pkg::ST_OK], status_seen[pst_pkg::ST_NOT_FOUND],
             status_seen[pst_pkg::ST_NO_SPACE], status_seen[pst_pkg::ST_FULL],
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS packet_subframe_table");
    end else begin
      $display("FAIL packet_subframe_table");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("FAIL packet_subframe_table");
    $finish;
  end

endmodule
